// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PLUA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PLUA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/plua_pkg.sv -----
// Types, constants and codes of the paged linear upload allocator.
package plua_pkg;

  localparam int NUM_SETS    = 3;
  localparam int MAX_PAGES   = 16;
  localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int PAGE_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W       = $clog2(MAX_PAGES + 1);
  localparam int FILL_W      = 25;
  localparam int ROW_W       = MAX_PAGES * FILL_W;
  localparam int TRIM_W      = 8;
  localparam int SHIFT_W     = 5;
  localparam int ALIGN_W     = 33;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FILL_W-1:0] PAGE_LIMIT      = 25'h100_0000;
  localparam logic [FILL_W-1:0] PAGE_SIZE_RESET = 25'h001_0000;
  localparam logic [TRIM_W-1:0] TRIM_RESET      = 8'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM      = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_RESET = 2'd1,
    REQ_CYCLE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_PAGE = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LANE,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [24:0] alloc_size;
    logic [4:0]  align_shift;
  } plua_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  set_index;
    logic [3:0]  page_index;
    logic [23:0] offset;
    logic [4:0]  page_count;
  } plua_out_t;

  // Classified request handed from front to back.
  typedef struct packed {
    req_e               kind;
    logic               too_big;
    logic [FILL_W-1:0]  size;
    logic [SHIFT_W-1:0] shift;
  } plua_work_t;

  typedef struct packed {
    logic [FILL_W-1:0] eff_size;
    logic [TRIM_W-1:0] trim;
  } plua_cfg_t;

endpackage

// ----- hdl/plua_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/plua_front.sv -----
// Front end: accepts request words, flags oversized ones and queues them.
module plua_front import plua_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FILL_W-1:0] eff_size_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plua_in_t          in_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output plua_work_t        pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  plua_work_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push, pop;
  plua_work_t          work;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = slot_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    work.kind    = req_e'(in_data_i.req_type);
    work.too_big = (in_data_i.alloc_size > eff_size_i);
    work.size    = in_data_i.alloc_size;
    work.shift   = in_data_i.align_shift;
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= work;
    end
  end

endmodule

// ----- hdl/plua_back.sv -----
// Back end: reads the set's fill row, evaluates all pages, commits and reports.
module plua_back import plua_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  plua_cfg_t  cfg_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  plua_work_t pop_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output plua_out_t  out_data_o
);

  back_state_e state_q, state_d;

  plua_work_t         item_q;
  logic [SET_W-1:0]   tgt_q, tgt_d;
  logic [SET_W-1:0]   active_q, active_d;
  logic [CNT_W-1:0]   po_q  [NUM_SETS];
  logic [PAGE_W-1:0]  cur_q [NUM_SETS];
  logic [PAGE_W-1:0]  hi_q  [NUM_SETS];
  logic [TRIM_W-1:0]  rst_q [NUM_SETS];
  logic [NUM_SETS-1:0] row_valid_q;

  logic [FILL_W-1:0]  row_q  [MAX_PAGES];
  logic [FILL_W-1:0]  alig_q [MAX_PAGES];
  logic [MAX_PAGES-1:0] room_q;
  logic [FILL_W-1:0]  row_d  [MAX_PAGES];
  logic [FILL_W-1:0]  alig_d [MAX_PAGES];
  logic [MAX_PAGES-1:0] room_d;

  logic               out_valid_q;
  plua_out_t          out_q, out_d;

  logic [SET_W-1:0]   ram_raddr;
  logic [ROW_W-1:0]   ram_rdata, ram_wdata;
  logic               ram_we;
  logic               commit;

  // Committed per-set values.
  logic [CNT_W-1:0]   po_n;
  logic [PAGE_W-1:0]  cur_n, hi_n;
  logic [TRIM_W-1:0]  rst_n;

  plua_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_valid_i) state_d = BK_LANE;
      BK_LANE: state_d = BK_DONE;
      BK_DONE: if (commit) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_ready_o = 1'b0;
    commit      = 1'b0;
    ram_raddr   = tgt_q;
    unique case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        ram_raddr   = tgt_d;
      end
      BK_LANE: ;
      BK_DONE: commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Target set: cycling moves to the next set in the ring.
  always_comb begin
    tgt_d = active_q;
    if (pop_data_i.kind == REQ_CYCLE) begin
      tgt_d = (active_q == SET_W'(NUM_SETS - 1)) ? '0 : active_q + 1'b1;
    end
  end

  // Lane evaluation: aligned fill and room of every page at once.
  always_comb begin
    logic [CNT_W-1:0]   po_eff;
    logic [FILL_W-1:0]  fill;
    logic [ALIGN_W-1:0] mask, al;
    po_eff = (po_q[tgt_q] == '0) ? CNT_W'(1) : po_q[tgt_q];
    mask   = (ALIGN_W'(1) << item_q.shift) - ALIGN_W'(1);
    for (int i = 0; i < MAX_PAGES; i++) begin
      fill = row_valid_q[tgt_q] ? ram_rdata[i*FILL_W +: FILL_W] : '0;
      if (i == 0 && po_q[tgt_q] == '0) begin
        fill = '0;
      end
      al        = (ALIGN_W'(fill) + mask) & ~mask;
      row_d[i]  = fill;
      alig_d[i] = al[FILL_W-1:0];
      room_d[i] = (CNT_W'(i) < po_eff) &&
                  ((ALIGN_W'(al) + ALIGN_W'(item_q.size)) <= ALIGN_W'(cfg_i.eff_size))
                  && (al < ALIGN_W'(PAGE_LIMIT) + ALIGN_W'(1));
    end
  end

  // Commit: pick the page, build the new row and the result word.
  always_comb begin
    logic [CNT_W-1:0]  po, po_eff;
    logic [PAGE_W-1:0] cur, hi, first, page;
    logic [TRIM_W-1:0] rcnt;
    logic              found, ok;
    logic [FILL_W-1:0] off, nrow [MAX_PAGES];
    po     = po_q[tgt_q];
    cur    = cur_q[tgt_q];
    hi     = hi_q[tgt_q];
    rcnt   = rst_q[tgt_q];
    po_eff = (po == '0) ? CNT_W'(1) : po;
    found  = 1'b0;
    first  = '0;
    for (int i = MAX_PAGES - 1; i >= 0; i--) begin
      if (room_q[i]) begin
        found = 1'b1;
        first = PAGE_W'(i);
      end
    end
    nrow     = row_q;
    ok       = 1'b1;
    off      = '0;
    page     = cur;
    active_d = active_q;
    ram_we   = 1'b0;
    po_n     = po;
    cur_n    = cur;
    hi_n     = hi;
    rst_n    = rcnt;
    out_d.status = ST_DONE;
    unique case (item_q.kind)
      REQ_ALLOC: begin
        if (item_q.too_big) begin
          out_d.status = ST_TOO_BIG;
        end else begin
          if (room_q[cur]) begin
            page = cur;
            off  = alig_q[cur];
          end else if (found) begin
            if (cur > hi) hi_n = cur;
            page = first;
            off  = alig_q[first];
          end else if (po_eff < CNT_W'(MAX_PAGES)) begin
            page   = po_eff[PAGE_W-1:0];
            off    = '0;
            po_eff = po_eff + 1'b1;
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            nrow[page]   = off + item_q.size;
            ram_we       = commit;
            po_n         = po_eff;
            cur_n        = page;
            out_d.status = ST_OK;
          end else begin
            out_d.status = ST_NO_PAGE;
          end
        end
      end
      REQ_RESET, REQ_CYCLE: begin
        if (item_q.kind == REQ_CYCLE) active_d = tgt_q;
        if (po != '0) begin
          for (int i = 0; i < MAX_PAGES; i++) begin
            nrow[i] = '0;
          end
          ram_we = commit;
          rst_n  = rcnt + 1'b1;
          if (cur > hi) hi_n = cur;
          if (rst_n >= cfg_i.trim) begin
            if (CNT_W'(hi_n) + CNT_W'(1) < po) po_n = CNT_W'(hi_n) + CNT_W'(1);
            rst_n = '0;
            hi_n  = '0;
          end
          cur_n = '0;
        end
      end
      REQ_NONE: ;
      default: ;
    endcase
    for (int i = 0; i < MAX_PAGES; i++) begin
      ram_wdata[i*FILL_W +: FILL_W] = nrow[i];
    end
    out_d.set_index  = 3'(active_d);
    out_d.page_index = 4'(cur_n);
    out_d.offset     = off[23:0];
    out_d.page_count = 5'(po_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      active_q    <= '0;
      tgt_q       <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        po_q[s]  <= '0;
        cur_q[s] <= '0;
        hi_q[s]  <= '0;
        rst_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE && pop_valid_i) begin
        tgt_q <= tgt_d;
      end
      if (commit) begin
        active_q     <= active_d;
        po_q[tgt_q]  <= po_n;
        cur_q[tgt_q] <= cur_n;
        hi_q[tgt_q]  <= hi_n;
        rst_q[tgt_q] <= rst_n;
        if (ram_we) row_valid_q[tgt_q] <= 1'b1;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && pop_valid_i) begin
      item_q <= pop_data_i;
    end
    if (state_q == BK_LANE) begin
      row_q  <= row_d;
      alig_q <= alig_d;
      room_q <= room_d;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/paged_linear_upload_allocator_core.sv -----
// Paged linear upload allocator: bump allocation over fixed-size pages in a ring of sets.
// Each request word gives exactly one result word. The front end takes a word whenever its
// two-entry queue has space; the back end then works through three steps per word (fill-row
// read, parallel room check over all pages, commit) and takes the next word from the queue
// only after that commit. The commit waits while the output register still holds a result
// that has not been taken. A result waits in an output register while the next words are
// taken in. Configuration must be written by the user through a plain write port only while
// the block is idle; the block does not enforce this. There is no clearing pass after reset.
module paged_linear_upload_allocator_core import plua_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FILL_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  plua_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output plua_out_t            out_data_o
);

  logic [FILL_W-1:0] page_size_q;
  logic [TRIM_W-1:0] trim_q;
  plua_cfg_t         cfg;
  logic              pop_valid, pop_ready;
  plua_work_t        pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RESET;
      trim_q      <= TRIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAGE_SIZE: page_size_q <= cfg_data_i;
        CFG_TRIM:      trim_q      <= cfg_data_i[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the largest page.
  assign cfg.eff_size = (page_size_q > PAGE_LIMIT) ? PAGE_LIMIT : page_size_q;
  assign cfg.trim     = trim_q;

  plua_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_size_i  (cfg.eff_size),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  plua_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/plua_checker.sv -----
// Port-level checker for the allocator core, bound to the top level.
`include "assert_macros.svh"

module plua_checker import plua_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input plua_out_t            out_data_o
);

  `PLUA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "result word dropped or changed while stalled")

  `PLUA_ASSERT_IMP(a_count_max, clk_i, rst_ni, out_valid_o,
    out_data_o.page_count <= 5'(MAX_PAGES), "page count above pool size")

  `PLUA_ASSERT_IMP(a_page_open, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_OK,
    5'(out_data_o.page_index) < out_data_o.page_count, "allocation on a page not open")

  `PLUA_ASSERT_IMP(a_err_offset, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK,
    out_data_o.offset == '0, "nonzero offset without allocation")

  `PLUA_ASSERT_IMP(a_set_range, clk_i, rst_ni, out_valid_o,
    out_data_o.set_index < 3'(NUM_SETS), "set index outside the ring")

endmodule

bind paged_linear_upload_allocator_core plua_checker u_plua_checker (.*);
